// ----- hw/rtl/utt_pkg.sv -----
`default_nettype none
package utt_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [15:0] HiSurFirst  = 16'hD800;
  localparam logic [15:0] HiSurLast   = 16'hDBFF;
  localparam logic [15:0] LoSurFirst  = 16'hDC00;
  localparam logic [15:0] LoSurLast   = 16'hDFFF;
  localparam logic [20:0] SuppBase    = 21'h10000;
  localparam logic [20:0] Replacement = 21'h00FFFD;

  // one queue entry: the scalars that a single input byte produces
  typedef struct packed {
    logic        pre;   // a U+FFFD goes out ahead of the main scalar
    logic        main;  // main scalar present
    logic [20:0] cp;    // main scalar value
    logic        last;  // request carried the end-of-stream mark
  } entry_t;

  // encoded length minus one
  function automatic logic [1:0] utf8_len(input logic [20:0] cp);
    logic [1:0] n;
    if (cp[20:16] != 5'd0) begin
      n = 2'd3;
    end else if (cp[15:11] != 5'd0) begin
      n = 2'd2;
    end else if (cp[10:7] != 4'd0) begin
      n = 2'd1;
    end else begin
      n = 2'd0;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (utf8_len(cp))
      2'd0: b = {1'b0, cp[6:0]};
      2'd1: begin
        case (idx)
          2'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      2'd2: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/utf16_to_utf8_transcoder.sv -----
// Path: an input byte that completes a scalar is written into the queue when its request is
//   accepted; its first UTF-8 byte then moves from the queue head into the output register.
// Throughput: one input byte per cycle while the queue has room; the single encoder in the back
//   end gives one output byte per cycle while the queue is not empty and the output not stalled.
// Reset: rst is synchronous, active high; clears byte order, held bytes, queue and output valid.
`default_nettype none
module utf16_to_utf8_transcoder (
  input  wire logic       clk,
  input  wire logic       rst,
  // byte order register: 1 = high byte first
  input  wire logic       cfg_wen,
  input  wire logic       cfg_wdata,
  // input stream
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,   // in_last
  // output stream
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast,   // run_last
  output logic            m_axis_tuser    // [0] stream_end
);

  utt_pkg::entry_t q_in;
  utt_pkg::entry_t q_head;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;

  // front: pairs bytes into units, resolves surrogates, queues a request for each byte with output
  utt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  // short queue decouples byte intake from byte emission
  utt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  // back: walks each request byte by byte into the output register
  utt_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (q_head),
    .empty          (q_empty),
    .pop            (q_pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_byte       (m_axis_tdata),
    .out_run_last   (m_axis_tlast),
    .out_stream_end (m_axis_tuser)
  );

  // end of stream is always also the end of a run
  a_end_is_run_last : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("stream_end without run_last");

  // a request leaves the queue only when the output register can take its last byte
  a_pop_needs_room : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!q_empty && (!m_axis_tvalid || m_axis_tready)))
    else $error("queue popped without output room");

  // nothing is presented in the cycle after reset
  a_reset_clears_out : assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule
`default_nettype wire

// ----- hw/rtl/utt_front.sv -----
`default_nettype none
module utt_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wen,
  input  wire logic             cfg_wdata,
  input  wire logic             in_valid,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_last,
  output logic                  in_ready,
  input  wire logic             q_full,
  output logic                  q_push,
  output utt_pkg::entry_t       q_entry
);

  logic       big_endian;
  logic [7:0] held_byte;
  logic       have_byte;
  logic [9:0] held_high;   // surrogate offset bits only
  logic       have_high;

  logic        accept;
  logic [15:0] unit;
  logic        is_hi;
  logic        is_lo;
  logic        hold_byte;
  logic        hold_high;
  logic [20:0] supp;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign unit  = big_endian ? {held_byte, in_byte} : {in_byte, held_byte};
  assign is_hi = (unit >= utt_pkg::HiSurFirst) && (unit <= utt_pkg::HiSurLast);
  assign is_lo = (unit >= utt_pkg::LoSurFirst) && (unit <= utt_pkg::LoSurLast);
  assign supp  = utt_pkg::SuppBase + {1'b0, held_high, unit[9:0]};

  always_comb begin
    q_entry      = '0;
    q_entry.last = in_last;
    hold_byte    = 1'b0;
    hold_high    = 1'b0;
    if (!have_byte) begin
      if (!in_last) begin
        hold_byte = 1'b1;
      end else begin
        q_entry.pre  = have_high;
        q_entry.main = 1'b1;
        q_entry.cp   = utt_pkg::Replacement;
      end
    end else if (have_high && is_lo) begin
      q_entry.main = 1'b1;
      q_entry.cp   = supp;
    end else begin
      // lone high surrogate pending: flag it, then treat unit as fresh
      q_entry.pre = have_high;
      if (is_hi) begin
        if (in_last) begin
          q_entry.main = 1'b1;
          q_entry.cp   = utt_pkg::Replacement;
        end else begin
          hold_high = 1'b1;
        end
      end else if (is_lo) begin
        q_entry.main = 1'b1;
        q_entry.cp   = utt_pkg::Replacement;
      end else begin
        q_entry.main = 1'b1;
        q_entry.cp   = {5'd0, unit};
      end
    end
  end

  assign q_push = accept && (q_entry.pre || q_entry.main);

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian <= 1'b0;
      have_byte  <= 1'b0;
      have_high  <= 1'b0;
      held_byte  <= 8'd0;
      held_high  <= 10'd0;
    end else begin
      if (cfg_wen) begin
        big_endian <= cfg_wdata;
      end
      if (accept) begin
        have_byte <= hold_byte;
        if (hold_byte) begin
          held_byte <= in_byte;
        end
        if (have_byte) begin
          have_high <= hold_high;
        end else if (in_last) begin
          have_high <= 1'b0;
        end
        if (hold_high) begin
          held_high <= unit[9:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/utt_queue.sv -----
`default_nettype none
module utt_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire utt_pkg::entry_t  push_entry,
  output logic                  full,
  input  wire logic             pop,
  output utt_pkg::entry_t       head,
  output logic                  empty
);

  utt_pkg::entry_t               slots [utt_pkg::QDepth];
  logic [utt_pkg::QPtrW-1:0]     wr_ptr;
  logic [utt_pkg::QPtrW-1:0]     rd_ptr;
  logic [utt_pkg::QPtrW:0]       count;
  logic                          do_push;
  logic                          do_pop;

  assign full    = (count == (utt_pkg::QPtrW+1)'(utt_pkg::QDepth));
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/utt_back.sv -----
`default_nettype none
module utt_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire utt_pkg::entry_t  head,
  input  wire logic             empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_run_last,
  output logic                  out_stream_end
);

  logic        in_main;   // past the leading replacement of this entry
  logic [1:0]  idx;
  logic        eff_main;
  logic [20:0] scalar;
  logic        scalar_end;
  logic        entry_end;
  logic        step;

  assign eff_main   = in_main || !head.pre;
  assign scalar     = eff_main ? head.cp : utt_pkg::Replacement;
  assign scalar_end = (idx == utt_pkg::utf8_len(scalar));
  assign entry_end  = scalar_end && (eff_main || !head.main);
  assign step       = !empty && (!out_valid || out_ready);
  assign pop        = step && entry_end;

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte       <= utt_pkg::utf8_byte(scalar, idx);
      out_run_last   <= entry_end;
      out_stream_end <= entry_end && head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      in_main   <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (step) begin
        if (entry_end) begin
          in_main <= 1'b0;
          idx     <= 2'd0;
        end else if (scalar_end) begin
          in_main <= 1'b1;
          idx     <= 2'd0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/utt_monitor.sv -----
`default_nettype none
module utt_monitor (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wen,
  input  wire logic       cfg_wdata,
  input  wire logic       s_axis_tvalid,
  input  wire logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,   // in_last
  input  wire logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  input  wire logic [7:0] m_axis_tdata,   // [7:0] out_byte
  input  wire logic       m_axis_tlast,   // run_last
  input  wire logic       m_axis_tuser,   // [0] stream_end
  output int              fail_count,
  output int              pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
  } utf8_byte_t;

  utf8_byte_t utf8_expected[$];

  // shadow of the transcoder state
  logic        order_be;
  logic [7:0]  held_byte;
  logic        have_byte;
  logic [15:0] held_high;
  logic        have_high;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (fail_count < 40) begin
      $display("mismatch %0t: %s got %02h want %02h", $time, what, got, want);
    end
    fail_count++;
  endtask

  task automatic push_utf8(input logic [7:0] b);
    utf8_expected.push_back('{b, 1'b0, 1'b0});
  endtask

  task automatic encode_scalar(input logic [20:0] cp);
    if (cp < 21'h80) begin
      push_utf8({1'b0, cp[6:0]});
    end else if (cp < 21'h800) begin
      push_utf8({3'b110, cp[10:6]});
      push_utf8({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      push_utf8({4'b1110, cp[15:12]});
      push_utf8({2'b10, cp[11:6]});
      push_utf8({2'b10, cp[5:0]});
    end else begin
      push_utf8({5'b11110, cp[20:18]});
      push_utf8({2'b10, cp[17:12]});
      push_utf8({2'b10, cp[11:6]});
      push_utf8({2'b10, cp[5:0]});
    end
  endtask

  // unit that does not close a pending high surrogate
  task automatic decode_fresh(input logic [15:0] u, input logic last);
    if (u >= utt_pkg::HiSurFirst && u <= utt_pkg::HiSurLast) begin
      if (last) begin
        encode_scalar(utt_pkg::Replacement);
      end else begin
        held_high = u;
        have_high = 1'b1;
      end
    end else if (u >= utt_pkg::LoSurFirst && u <= utt_pkg::LoSurLast) begin
      encode_scalar(utt_pkg::Replacement);
    end else begin
      encode_scalar({5'd0, u});
    end
  endtask

  task automatic predict_utf8(input logic [7:0] b, input logic last);
    logic [15:0] u;
    logic [20:0] cp;
    int          first;
    utf8_byte_t  tail;
    first = utf8_expected.size();
    if (!have_byte) begin
      if (!last) begin
        held_byte = b;
        have_byte = 1'b1;
      end else begin
        // odd final byte; a pending high goes out first
        if (have_high) begin
          encode_scalar(utt_pkg::Replacement);
          have_high = 1'b0;
        end
        encode_scalar(utt_pkg::Replacement);
      end
    end else begin
      u = order_be ? {held_byte, b} : {b, held_byte};
      have_byte = 1'b0;
      if (have_high) begin
        have_high = 1'b0;
        if (u >= utt_pkg::LoSurFirst && u <= utt_pkg::LoSurLast) begin
          cp = utt_pkg::SuppBase + (21'(held_high - utt_pkg::HiSurFirst) << 10)
             + 21'(u - utt_pkg::LoSurFirst);
          encode_scalar(cp);
        end else begin
          encode_scalar(utt_pkg::Replacement);
          decode_fresh(u, last);
        end
      end else begin
        decode_fresh(u, last);
      end
    end
    if (last) begin
      held_byte = 8'd0;
      have_byte = 1'b0;
      held_high = 16'd0;
      have_high = 1'b0;
    end
    if (utf8_expected.size() > first) begin
      tail = utf8_expected[utf8_expected.size() - 1];
      tail.run_last = 1'b1;
      if (last) tail.stream_end = 1'b1;
      utf8_expected[utf8_expected.size() - 1] = tail;
    end
  endtask

  task automatic compare_output();
    utf8_byte_t want;
    if (utf8_expected.size() == 0) begin
      report_mismatch("byte with nothing expected", m_axis_tdata, 8'h00);
    end else begin
      want = utf8_expected.pop_front();
      if (m_axis_tdata != want.data) begin
        report_mismatch("out_byte", m_axis_tdata, want.data);
      end
      if (m_axis_tlast != want.run_last) begin
        report_mismatch("run_last", {7'd0, m_axis_tlast}, {7'd0, want.run_last});
      end
      if (m_axis_tuser != want.stream_end) begin
        report_mismatch("stream_end", {7'd0, m_axis_tuser}, {7'd0, want.stream_end});
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      order_be  = 1'b0;
      held_byte = 8'd0;
      have_byte = 1'b0;
      held_high = 16'd0;
      have_high = 1'b0;
      utf8_expected.delete();
    end else begin
      if (cfg_wen) order_be = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) predict_utf8(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) compare_output();
    end
    pending <= utf8_expected.size();
  end

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none
module tb;

  // kinds of UTF-16 content the random streams are built from
  typedef enum logic [2:0] {
    KindAscii,
    KindTwoByte,
    KindThreeByte,
    KindPair,
    KindLoneHigh,
    KindLoneLow,
    KindRaw
  } unit_kind_e;

  logic       clk;
  logic       rst;
  logic       cfg_wen;
  logic       cfg_wdata;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;    // [7:0] in_byte
  logic       s_axis_tlast;    // in_last
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b1;
  logic [7:0] m_axis_tdata;    // [7:0] out_byte
  logic       m_axis_tlast;    // run_last
  logic       m_axis_tuser;    // [0] stream_end

  int fail_count;
  int pending;       // output bytes still owed by the block
  int sent;          // input requests accepted so far
  int rx_left = 0;   // cycles left in the current ready/stall stretch
  bit calm;          // no idling on either side while set
  bit stream_be;     // byte order the stimulus currently uses

  utf16_to_utf8_transcoder uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  utt_monitor mon (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // downstream back-pressure: alternate ready runs and stalls
  always @(posedge clk) begin
    if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else if (m_axis_tready) begin
      int stall;
      stall = pick_gap();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        rx_left       <= stall - 1;
      end else begin
        rx_left <= $urandom_range(0, 15);
      end
    end else begin
      m_axis_tready <= 1'b1;
      rx_left       <= $urandom_range(0, 15);
    end
  end

  // one input request; tvalid stays up across back-to-back requests
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  // a 16-bit code unit in the current byte order; last rides on its second byte
  task automatic send_unit(input logic [15:0] u, input logic last);
    if (stream_be) begin
      send_byte(u[15:8], 1'b0);
      send_byte(u[7:0], last);
    end else begin
      send_byte(u[7:0], 1'b0);
      send_byte(u[15:8], last);
    end
  endtask

  // byte order changes only once the block has drained
  task automatic set_order(input bit be);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);   // let a held byte settle inside the block
    cfg_wen   <= 1'b1;
    cfg_wdata <= be;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    stream_be = be;
  endtask

  function automatic unit_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return KindAscii;
    if (r < 35) return KindTwoByte;
    if (r < 55) return KindThreeByte;
    if (r < 80) return KindPair;
    if (r < 87) return KindLoneHigh;
    if (r < 93) return KindLoneLow;
    return KindRaw;
  endfunction

  task automatic send_scalar(input logic last);
    unit_kind_e kind;
    kind = pick_kind();
    case (kind)
      KindAscii:     send_unit(16'($urandom_range(0, 'h7F)), last);
      KindTwoByte:   send_unit(16'($urandom_range('h80, 'h7FF)), last);
      KindThreeByte: send_unit(16'($urandom_range('h800, 'hFFFF)), last);
      KindPair: begin
        send_unit(utt_pkg::HiSurFirst + 16'($urandom_range(0, 'h3FF)), 1'b0);
        send_unit(utt_pkg::LoSurFirst + 16'($urandom_range(0, 'h3FF)), last);
      end
      KindLoneHigh:  send_unit(utt_pkg::HiSurFirst + 16'($urandom_range(0, 'h3FF)), last);
      KindLoneLow:   send_unit(utt_pkg::LoSurFirst + 16'($urandom_range(0, 'h3FF)), last);
      default:       send_unit(16'($urandom), last);
    endcase
  endtask

  // a stream of a few scalars, sometimes cut off by an odd final byte
  task automatic send_random_stream();
    int  n_units;
    bit  odd_end;
    int  k;
    n_units = $urandom_range(1, 8);
    odd_end = ($urandom_range(0, 5) == 0);
    for (k = 0; k < n_units; k++) begin
      send_scalar((k == n_units - 1) && !odd_end);
    end
    if (odd_end) send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    int wait_cycles;
    int phase;
    rst           = 1'b1;
    cfg_wen       = 1'b0;
    cfg_wdata     = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tlast  = 1'b0;
    calm          = 1'b0;
    stream_be     = 1'b0;
    sent          = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed, little endian after reset
    send_unit(16'h07FF, 1'b0);          // top of the two-byte range
    send_unit(16'hFFFF, 1'b0);          // top of the three-byte range
    send_unit(16'hDBFF, 1'b0);          // pair giving U+10FFFF
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'hDC00, 1'b0);          // lone low surrogate
    send_unit(16'hD800, 1'b0);          // lone high, then the next high pairs up
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hD800, 1'b0);          // odd final byte behind a pending high
    send_byte(8'h7F, 1'b1);

    // byte order flips while the first byte of a unit is held
    send_byte(8'h12, 1'b0);
    set_order(1'b1);
    send_byte(8'h34, 1'b0);
    send_unit(16'hD800, 1'b0);          // high completed by the final byte,
    send_unit(16'hDBFF, 1'b1);          //   with another high pending
    send_byte(8'h55, 1'b1);             // lone final byte on a fresh stream

    // random streams, byte order toggled between phases, one phase without idling
    for (phase = 0; phase < 4; phase++) begin
      set_order(phase[0]);
      calm = (phase == 2);
      while (sent < 26 + 50 * (phase + 1)) send_random_stream();
    end
    calm = 1'b0;

    s_axis_tvalid <= 1'b0;
    wait_cycles = 0;
    do begin
      @(posedge clk);
      wait_cycles++;
    end while (pending != 0 && wait_cycles < 100000);
    repeat (16) @(posedge clk);   // catch any stray output bytes

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/utt_pkg.sv
hw/rtl/utt_front.sv
hw/rtl/utt_queue.sv
hw/rtl/utt_back.sv
hw/rtl/utf16_to_utf8_transcoder.sv
tb/sv/utt_monitor.sv
tb/sv/tb.sv
